// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/cgwm_pkg.sv -----
`timescale 1ns / 1ps
package cgwm_pkg;

    localparam int MAX_BOARD_SIDE   = 256;
    localparam int MAX_PATTERN_SIDE = 256;
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int SYM_W   = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SYM_W-1:0] SYM_WILDCARD = 5'd26;

    localparam logic [1:0] REQ_BOARD   = 2'd0;
    localparam logic [1:0] REQ_PATTERN = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    localparam logic [2:0] CFG_BOARD_ROWS   = 3'd0;
    localparam logic [2:0] CFG_BOARD_COLS   = 3'd1;
    localparam logic [2:0] CFG_PATTERN_ROWS = 3'd2;
    localparam logic [2:0] CFG_PATTERN_COLS = 3'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SYM_W-1:0]   symbol;
    } entry_t;

    typedef struct packed {
        logic [DIM_W-1:0] board_rows;
        logic [DIM_W-1:0] board_cols;
        logic [DIM_W-1:0] pattern_rows;
        logic [DIM_W-1:0] pattern_cols;
    } dims_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic busy;
        logic result_pend;
    } bstat_t;

endpackage

// ----- src/cgwm_front.sv -----
`timescale 1ns / 1ps
module cgwm_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,
    input  logic [1:0]              s_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [8:0]              cfg_data,
    input  cgwm_pkg::qstat_t        q_stat,
    output logic                    q_push,
    output cgwm_pkg::entry_t        q_entry,
    output cgwm_pkg::dims_t         dims
);

    localparam logic [cgwm_pkg::DIM_W-1:0] BMAX = cgwm_pkg::DIM_W'(cgwm_pkg::MAX_BOARD_SIDE);
    localparam logic [cgwm_pkg::DIM_W-1:0] PMAX =
        cgwm_pkg::DIM_W'(cgwm_pkg::MAX_PATTERN_SIDE);

    cgwm_pkg::dims_t dims_reg;
    logic [cgwm_pkg::DIM_W-1:0] bdim_next;
    logic [cgwm_pkg::DIM_W-1:0] pdim_next;

    always_comb
    begin
        bdim_next = cfg_data;
        if (cfg_data == '0)
            bdim_next = 9'd1;
        else if (cfg_data > BMAX)
            bdim_next = BMAX;
        pdim_next = cfg_data;
        if (cfg_data == '0)
            pdim_next = 9'd1;
        else if (cfg_data > PMAX)
            pdim_next = PMAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.board_rows   <= 9'd1;
            dims_reg.board_cols   <= 9'd1;
            dims_reg.pattern_rows <= 9'd1;
            dims_reg.pattern_cols <= 9'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cgwm_pkg::CFG_BOARD_ROWS:   dims_reg.board_rows   <= bdim_next;
                cgwm_pkg::CFG_BOARD_COLS:   dims_reg.board_cols   <= bdim_next;
                cgwm_pkg::CFG_PATTERN_ROWS: dims_reg.pattern_rows <= pdim_next;
                cgwm_pkg::CFG_PATTERN_COLS: dims_reg.pattern_cols <= pdim_next;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign dims      = dims_reg;

    // unknown request codes are consumed and dropped here
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full &&
                      (s_tuser == cgwm_pkg::REQ_BOARD || s_tuser == cgwm_pkg::REQ_PATTERN ||
                       s_tuser == cgwm_pkg::REQ_QUERY);

    assign q_entry.req_type = s_tuser;
    assign q_entry.row      = s_tdata[7:0];
    assign q_entry.col      = s_tdata[15:8];
    assign q_entry.symbol   = s_tdata[20:16];

endmodule

// ----- src/cgwm_queue.sv -----
`timescale 1ns / 1ps
module cgwm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cgwm_pkg::entry_t    push_entry,
    input  logic                pop,
    output cgwm_pkg::entry_t    head,
    output cgwm_pkg::qstat_t    stat
);

    localparam int PTR_W = $clog2(cgwm_pkg::QUEUE_DEPTH);

    cgwm_pkg::entry_t slots_reg [cgwm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    assign head       = slots_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PTR_W+1)'(cgwm_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- src/cgwm_back.sv -----
`timescale 1ns / 1ps
module cgwm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cgwm_pkg::dims_t     dims,
    input  cgwm_pkg::qstat_t    q_stat,
    input  cgwm_pkg::entry_t    head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output cgwm_pkg::bstat_t    stat
);

    localparam int BDEPTH = cgwm_pkg::MAX_BOARD_SIDE * cgwm_pkg::MAX_BOARD_SIDE;
    localparam int PDEPTH = cgwm_pkg::MAX_PATTERN_SIDE * cgwm_pkg::MAX_PATTERN_SIDE;
    localparam int CW = cgwm_pkg::COORD_W;
    localparam int DW = cgwm_pkg::DIM_W;
    localparam int SW = cgwm_pkg::SYM_W;
    localparam int WW = CW + DW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_LAST,
        ST_RESULT
    } state_t;

    logic [SW-1:0] board_mem   [BDEPTH];
    logic [SW-1:0] pattern_mem [PDEPTH];

    state_t        state_reg;
    logic [2:0]    k_reg;
    logic [CW-1:0] qr_reg, qc_reg;
    logic [CW-1:0] rmod_reg, cmod_reg;
    logic [CW-1:0] x_reg, y_reg, br_reg, bc_reg, bc0_reg;
    logic          match_reg;
    logic          cmp_vld_reg;
    logic [SW-1:0] pat_rd_reg, brd_rd_reg;
    logic          out_valid_reg;
    logic [16:0]   out_data_reg;

    logic [WW-1:0] rsh, csh, rext, cext;
    logic [CW-1:0] rmod_next, cmod_next;
    logic          match_next;
    logic          y_last, x_last;
    logic [CW-1:0] br_inc, bc_inc;
    logic          mem_we_board, mem_we_pat, walk_rd;
    logic          out_load;

    // one restoring step of (row mod board_rows) and (col mod board_cols) per cycle
    always_comb
    begin
        rext = WW'(rmod_reg);
        cext = WW'(cmod_reg);
        rsh  = WW'(dims.board_rows) << k_reg;
        csh  = WW'(dims.board_cols) << k_reg;
        rmod_next = (rext >= rsh) ? CW'(rext - rsh) : rmod_reg;
        cmod_next = (cext >= csh) ? CW'(cext - csh) : cmod_reg;
    end

    always_comb
    begin
        y_last = ((DW'(y_reg) + 1'b1) == dims.pattern_cols);
        x_last = ((DW'(x_reg) + 1'b1) == dims.pattern_rows);
        br_inc = ((DW'(br_reg) + 1'b1) == dims.board_rows) ? '0 : br_reg + 1'b1;
        bc_inc = ((DW'(bc_reg) + 1'b1) == dims.board_cols) ? '0 : bc_reg + 1'b1;
        match_next = match_reg;
        if (cmp_vld_reg && pat_rd_reg != cgwm_pkg::SYM_WILDCARD && pat_rd_reg != brd_rd_reg)
            match_next = 1'b0;
    end

    assign pop          = (state_reg == ST_IDLE) && !q_stat.empty;
    assign mem_we_board = pop && head.req_type == cgwm_pkg::REQ_BOARD;
    assign mem_we_pat   = pop && head.req_type == cgwm_pkg::REQ_PATTERN;
    assign walk_rd      = (state_reg == ST_WALK);
    assign out_load     = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (mem_we_board)
            board_mem[{head.row, head.col}] <= head.symbol;
        if (walk_rd)
            brd_rd_reg <= board_mem[{br_reg, bc_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we_pat)
            pattern_mem[{head.row, head.col}] <= head.symbol;
        if (walk_rd)
            pat_rd_reg <= pattern_mem[{x_reg, y_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            match_reg     <= 1'b1;
            qr_reg        <= '0;
            qc_reg        <= '0;
            rmod_reg      <= '0;
            cmod_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            br_reg        <= '0;
            bc_reg        <= '0;
            bc0_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            cmp_vld_reg <= walk_rd;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && head.req_type == cgwm_pkg::REQ_QUERY)
                    begin
                        qr_reg    <= head.row;
                        qc_reg    <= head.col;
                        rmod_reg  <= head.row;
                        cmod_reg  <= head.col;
                        k_reg     <= 3'd7;
                        match_reg <= 1'b1;
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD:
                begin
                    rmod_reg <= rmod_next;
                    cmod_reg <= cmod_next;
                    k_reg    <= k_reg - 1'b1;
                    if (k_reg == '0)
                    begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        br_reg    <= rmod_next;
                        bc_reg    <= cmod_next;
                        bc0_reg   <= cmod_next;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    match_reg <= match_next;
                    if (y_last)
                    begin
                        y_reg  <= '0;
                        x_reg  <= x_reg + 1'b1;
                        bc_reg <= bc0_reg;
                        br_reg <= br_inc;
                        if (x_last)
                            state_reg <= ST_LAST;
                    end
                    else
                    begin
                        y_reg  <= y_reg + 1'b1;
                        bc_reg <= bc_inc;
                    end
                end
                ST_LAST:
                begin
                    match_reg <= match_next;
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_load)
                    begin
                        out_data_reg  <= {qc_reg, qr_reg, match_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = {7'd0, out_data_reg};
    assign stat.busy        = (state_reg != ST_IDLE);
    assign stat.result_pend = (state_reg == ST_RESULT);

endmodule

// ----- src/cyclic_grid_wildcard_match_core.sv -----
`timescale 1ns / 1ps
// Loads are written to the back-end memories as they are popped; a query runs 8
// mod-reduction steps, then compares one pattern/board cell per cycle through the single
// read ports before its result is registered.
// A 4-entry queue lets loads keep arriving while a result waits on m_tready.
// rst_n is asynchronous, active low; it clears control state and sets all
// dimensions to 1. Board and pattern memories are not cleared.
`include "assert_macros.svh"
module cyclic_grid_wildcard_match_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[7:0], col[15:8], symbol[20:16], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // match[0], query_row[8:1], query_col[16:9], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    cgwm_pkg::qstat_t q_stat;
    cgwm_pkg::bstat_t b_stat;
    cgwm_pkg::entry_t q_entry;
    cgwm_pkg::entry_t q_head;
    cgwm_pkg::dims_t  dims;
    logic             q_push;
    logic             q_pop;

    cgwm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .dims      (dims)
    );

    cgwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    cgwm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .dims     (dims),
        .q_stat   (q_stat),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (b_stat)
    );

    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_push, !q_stat.full, "push into full queue")
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_pop_idle, clk, rst_n, q_pop, !b_stat.busy, "pop while back end busy")
    `ASSERT_IMPLIES(a_result_src, clk, rst_n, $rose(m_tvalid), $past(b_stat.result_pend),
                    "result without finished query")

endmodule
